[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros, sampled on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GRWC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GRWC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/grwc_pkg.sv]
// ----------------------------------------------------------------------------
// grwc_pkg
// Types, register indexes and constants of the grid ray wall caster.
// ----------------------------------------------------------------------------
package grwc_pkg;

	localparam int MAP_WIDTH_DEF  = 32;
	localparam int MAP_HEIGHT_DEF = 32;

	localparam int DIV_W   = 32;
	localparam int DVS_W   = 16;
	localparam int DEPTH_W = 38;

	localparam logic [1:0] REG_SCREEN_DEPTH = 2'd0;
	localparam logic [1:0] REG_HALF_HEIGHT  = 2'd1;
	localparam logic [1:0] REG_MAX_STEPS    = 2'd2;
	localparam logic [1:0] REG_COLUMN_WIDTH = 2'd3;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_CAST  = 1'b1;

	localparam logic [15:0] SCREEN_DEPTH_RST = 16'd400;
	localparam logic [10:0] HALF_HEIGHT_RST  = 11'd300;
	localparam logic [6:0]  MAX_STEPS_RST    = 7'd20;
	localparam logic [4:0]  COLUMN_WIDTH_RST = 5'd2;

	typedef struct packed {
		logic               action;
		logic [4:0]         cell_x;
		logic [4:0]         cell_y;
		logic [3:0]         cell_value;
		logic [15:0]        player_x;
		logic [15:0]        player_y;
		logic signed [15:0] ray_cos;
		logic signed [15:0] ray_sin;
		logic [14:0]        fisheye_cos;
		logic [9:0]         column;
	} in_word_t;

	typedef struct packed {
		logic [9:0]         screen_column;
		logic [13:0]        screen_x;
		logic [15:0]        wall_depth;
		logic [3:0]         texture_id;
		logic [7:0]         tex_offset;
		logic               hit_side;
		logic [11:0]        column_height;
		logic signed [11:0] top_row;
	} out_word_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic               hit;
		logic [DEPTH_W-1:0] depth;
		logic [7:0]         off;
		logic [3:0]         tex;
	} cand_t;

endpackage

[hdl/grwc_div.sv]
// ----------------------------------------------------------------------------
// grwc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module grwc_div
	import grwc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DIV_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	`GRWC_ASSERT_IMP(a_done_after_busy, done_q, $past(busy_q), "divider done without a run")

endmodule

[hdl/grwc_map_mem.sv]
// ----------------------------------------------------------------------------
// grwc_map_mem
// Tile map store with a registered read port and a clearing pass after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module grwc_map_mem
	import grwc_pkg::*;
#(
	parameter int MAP_WIDTH  = MAP_WIDTH_DEF,
	parameter int MAP_HEIGHT = MAP_HEIGHT_DEF,
	parameter int ADDR_W     = $clog2(MAP_WIDTH * MAP_HEIGHT)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [3:0]        wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [3:0]        rd_data,
	output logic              clearing
);

	localparam int DEPTH = MAP_WIDTH * MAP_HEIGHT;

	logic [3:0]        cells [DEPTH];
	logic              clr_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [3:0]        rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			cells[clr_addr_q] <= 4'd0;
		end else if (wr_en) begin
			cells[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= cells[rd_addr];
		end
	end

	assign rd_data  = rd_data_q;
	assign clearing = clr_q;

	`GRWC_ASSERT_IMP(a_no_write_in_clear, clr_q, !wr_en, "map write during clearing pass")

endmodule

[hdl/grid_ray_wall_caster_top.sv]
// ----------------------------------------------------------------------------
// grid_ray_wall_caster_top
// A write word stores one map cell. A cast word walks the vertical grid
// lines, then the horizontal ones, and returns one result word. Each
// direction with a nonzero component has a setup step, two divisions and,
// per map cell checked, a multiply, an address and a map read step. A
// direction with a zero component has only its setup step. Then come
// selection and, if a wall was hit, fisheye correction and, unless the
// corrected depth is zero, the height division. All divisions share one
// bit-serial divider, and all map reads use the single map read port.
// After reset the map is cleared one cell a cycle (MAP_WIDTH * MAP_HEIGHT
// cells, 1024 by default) and no word is taken until that pass ends. The
// result sits in an output register, so the next word is taken while it
// waits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module grid_ray_wall_caster_top
	import grwc_pkg::*;
#(
	parameter int MAP_WIDTH  = MAP_WIDTH_DEF,
	parameter int MAP_HEIGHT = MAP_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_word_t    in_word,
	output logic        out_valid,
	input  logic        out_stall,
	output out_word_t   out_word
);

	localparam int ADDR_W = $clog2(MAP_WIDTH * MAP_HEIGHT);

	typedef enum logic [10:0] {
		ST_IDLE      = 11'b00000000001,
		ST_SETUP     = 11'b00000000010,
		ST_DIV_FIRST = 11'b00000000100,
		ST_DIV_STEP  = 11'b00000001000,
		ST_MUL       = 11'b00000010000,
		ST_ADDR      = 11'b00000100000,
		ST_CHECK     = 11'b00001000000,
		ST_SEL       = 11'b00010000000,
		ST_FISH      = 11'b00100000000,
		ST_SAT       = 11'b01000000000,
		ST_DONE      = 11'b10000000000
	} state_t;

	state_t state_q;
	logic   div_h_q;

	logic [15:0] screen_depth_q;
	logic [10:0] half_height_q;
	logic [6:0]  max_steps_q;
	logic [4:0]  column_width_q;

	in_word_t           in_q;
	logic               dir_q;
	logic [6:0]         k_q;
	logic [DEPTH_W-1:0] depth_q;
	logic [30:0]        step_q;
	logic [53:0]        prod_q;
	logic signed [41:0] other_q;
	logic               oob_q;
	cand_t              cand_v_q;
	cand_t              cand_h_q;
	cand_t              sel_q;
	logic               side_q;
	logic [52:0]        fprod_q;
	logic [15:0]        wdepth_q;
	logic [11:0]        height_q;
	out_word_t          out_q;
	logic               out_valid_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic              clearing;
	logic [3:0]        rd_data;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic              in_acc;

	logic [15:0]        pm;
	logic [15:0]        po;
	logic signed [16:0] rc17;
	logic signed [16:0] rs_neg;
	logic signed [16:0] vm;
	logic signed [16:0] vo;
	logic [16:0]        vm_abs;
	logic [16:0]        vo_abs;
	logic [15:0]        am;
	logic [15:0]        ao;
	logic               vm_zero;
	logic               vm_pos;
	logic [5:0]         line;
	logic [16:0]        line_gap;
	logic [39:0]        mag;
	logic signed [41:0] po16;
	logic signed [41:0] other;
	logic [9:0]         cm;
	logic               cm_oob;
	logic               co_oob;
	logic [7:0]         x8;
	logic [7:0]         y8;
	logic [31:0]        cm_lim;
	logic [31:0]        co_lim;
	logic               wall;
	logic               exhausted;
	logic               direct;
	logic [15:0]        frac;
	logic [16:0]        inv_frac;
	logic [7:0]         off;
	cand_t              cand_new;
	logic [30:0]        corr;
	logic [15:0]        dep16;
	logic               v_wins;
	logic               out_load;
	logic [14:0]        sx_full;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE) || clearing;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_depth_q <= SCREEN_DEPTH_RST;
			half_height_q  <= HALF_HEIGHT_RST;
			max_steps_q    <= MAX_STEPS_RST;
			column_width_q <= COLUMN_WIDTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCREEN_DEPTH: screen_depth_q <= cfg_data;
				REG_HALF_HEIGHT:  half_height_q  <= cfg_data[10:0];
				REG_MAX_STEPS:    max_steps_q    <= cfg_data[6:0];
				REG_COLUMN_WIDTH: column_width_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// per-direction operands
	assign rc17    = 17'(in_q.ray_cos);
	assign rs_neg  = -17'(in_q.ray_sin);
	assign pm      = dir_q ? in_q.player_y : in_q.player_x;
	assign po      = dir_q ? in_q.player_x : in_q.player_y;
	assign vm      = dir_q ? rs_neg : rc17;
	assign vo      = dir_q ? rc17 : rs_neg;
	assign vm_abs  = vm[16] ? 17'(-vm) : 17'(vm);
	assign vo_abs  = vo[16] ? 17'(-vo) : 17'(vo);
	assign am      = vm_abs[15:0];
	assign ao      = vo_abs[15:0];
	assign vm_zero = (vm == '0);
	assign vm_pos  = !vm[16] && !vm_zero;
	assign line    = {1'b0, pm[15:11]} + {5'd0, vm_pos};
	assign line_gap = vm_pos ? (17'h10000 - {1'b0, pm[10:0], 5'd0})
	                         : {1'b0, pm[10:0], 5'd0};

	// cross coordinate and map cell
	assign mag    = prod_q[53:14];
	assign po16   = $signed({21'd0, po, 5'd0});
	assign other  = vo[16] ? (po16 - $signed({2'b0, mag})) : (po16 + $signed({2'b0, mag}));
	assign cm     = vm_pos ? (10'(line) + 10'(k_q)) : (10'(line) - 10'd1 - 10'(k_q));
	assign cm_lim = dir_q ? 32'(MAP_HEIGHT) : 32'(MAP_WIDTH);
	assign co_lim = dir_q ? 32'(MAP_WIDTH) : 32'(MAP_HEIGHT);
	assign cm_oob = cm[9] || ({22'd0, cm} >= cm_lim);
	assign co_oob = other[41] || ({6'd0, other[41:16]} >= co_lim);
	assign x8     = dir_q ? other[23:16] : cm[7:0];
	assign y8     = dir_q ? cm[7:0] : other[23:16];
	assign rd_addr = ADDR_W'(32'(y8) * 32'(MAP_WIDTH) + 32'(x8));

	// check of one cell
	assign wall      = oob_q || (rd_data != 4'd0);
	assign exhausted = k_q >= max_steps_q;
	assign direct    = dir_q ? vm[16] : vm_pos;
	assign frac      = other_q[15:0];
	assign inv_frac  = 17'h10000 - {1'b0, frac};
	assign off       = direct ? frac[15:8] : (inv_frac[16] ? 8'hFF : inv_frac[15:8]);
	assign cand_new  = '{hit: 1'b1, depth: depth_q, off: off,
	                     tex: (oob_q ? 4'd0 : rd_data)};

	assign v_wins = cand_v_q.hit && (!cand_h_q.hit || (cand_v_q.depth < cand_h_q.depth));
	assign corr   = fprod_q[52:22];
	assign dep16  = (|corr[30:16]) ? 16'hFFFF : corr[15:0];

	// map writes from write words
	assign wr_en   = in_acc && (in_word.action == ACT_WRITE)
	                 && (32'(in_word.cell_x) < 32'(MAP_WIDTH))
	                 && (32'(in_word.cell_y) < 32'(MAP_HEIGHT));
	assign wr_addr = ADDR_W'(32'(in_word.cell_y) * 32'(MAP_WIDTH) + 32'(in_word.cell_x));

	// divider requests
	always_comb begin
		div_req = '0;
		case (state_q)
			ST_SETUP: begin
				div_req.start    = !vm_zero;
				div_req.dividend = {1'b0, line_gap, 14'd0};
				div_req.divisor  = am;
			end
			ST_DIV_FIRST: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = 32'h4000_0000;
				div_req.divisor  = am;
			end
			ST_SAT: begin
				div_req.start    = !div_h_q && (dep16 != 16'd0);
				div_req.dividend = {8'd0, screen_depth_q, 8'd0};
				div_req.divisor  = dep16;
			end
			default: ;
		endcase
	end

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			div_h_q <= 1'b0;
			dir_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && in_word.action == ACT_CAST) begin
						dir_q   <= 1'b0;
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					if (!vm_zero) begin
						state_q <= ST_DIV_FIRST;
					end else if (dir_q) begin
						state_q <= ST_SEL;
					end else begin
						dir_q <= 1'b1;
					end
				end
				ST_DIV_FIRST: if (div_rsp.done) state_q <= ST_DIV_STEP;
				ST_DIV_STEP:  if (div_rsp.done) state_q <= ST_MUL;
				ST_MUL:       state_q <= ST_ADDR;
				ST_ADDR:      state_q <= ST_CHECK;
				ST_CHECK: begin
					if (wall || exhausted) begin
						if (dir_q) begin
							state_q <= ST_SEL;
						end else begin
							dir_q   <= 1'b1;
							state_q <= ST_SETUP;
						end
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_SEL: begin
					state_q <= (cand_v_q.hit || cand_h_q.hit) ? ST_FISH : ST_DONE;
				end
				ST_FISH: state_q <= ST_SAT;
				ST_SAT: begin
					if (!div_h_q) begin
						if (dep16 == 16'd0) begin
							state_q <= ST_DONE;
						end else begin
							div_h_q <= 1'b1;
						end
					end else if (div_rsp.done) begin
						div_h_q <= 1'b0;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && in_word.action == ACT_CAST) begin
			in_q     <= in_word;
			cand_v_q <= '0;
			cand_h_q <= '0;
		end
		if (state_q == ST_DIV_FIRST && div_rsp.done) begin
			depth_q <= DEPTH_W'(div_rsp.quotient);
		end
		if (state_q == ST_DIV_STEP && div_rsp.done) begin
			step_q <= div_rsp.quotient[30:0];
			k_q    <= '0;
		end
		if (state_q == ST_MUL) begin
			prod_q <= 54'(depth_q) * 54'(ao);
		end
		if (state_q == ST_ADDR) begin
			other_q <= other;
			oob_q   <= cm_oob || co_oob;
		end
		if (state_q == ST_CHECK) begin
			if (wall || exhausted) begin
				if (dir_q) cand_h_q <= cand_new;
				else       cand_v_q <= cand_new;
			end else begin
				depth_q <= depth_q + DEPTH_W'(step_q);
				k_q     <= k_q + 7'd1;
			end
		end
		if (state_q == ST_SEL) begin
			sel_q  <= v_wins ? cand_v_q : cand_h_q;
			side_q <= !v_wins;
			if (!(cand_v_q.hit || cand_h_q.hit)) begin
				wdepth_q <= 16'hFFFF;
				height_q <= 12'd0;
			end
		end
		if (state_q == ST_FISH) begin
			fprod_q <= 53'(sel_q.depth) * 53'(in_q.fisheye_cos);
		end
		if (state_q == ST_SAT) begin
			if (!div_h_q) begin
				wdepth_q <= dep16;
				if (dep16 == 16'd0) height_q <= 12'hFFF;
			end else if (div_rsp.done) begin
				height_q <= (|div_rsp.quotient[31:12]) ? 12'hFFF : div_rsp.quotient[11:0];
			end
		end
	end

	// output register
	assign sx_full = 15'(in_q.column) * 15'(column_width_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.screen_column <= in_q.column;
			out_q.screen_x      <= sx_full[13:0];
			out_q.wall_depth    <= wdepth_q;
			out_q.texture_id    <= sel_q.tex;
			out_q.tex_offset    <= sel_q.off;
			out_q.hit_side      <= side_q;
			out_q.column_height <= height_q;
			out_q.top_row       <= $signed({1'b0, half_height_q} - {1'b0, height_q[11:1]});
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	grwc_map_mem #(
		.MAP_WIDTH  (MAP_WIDTH),
		.MAP_HEIGHT (MAP_HEIGHT),
		.ADDR_W     (ADDR_W)
	) u_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (in_word.cell_value),
		.rd_en    (state_q == ST_ADDR),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.clearing (clearing)
	);

	grwc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	`GRWC_ASSERT_IMP(a_div_start_idle, div_req.start, !div_rsp.busy, "divider restarted while busy")
	`GRWC_ASSERT_NEXT(a_read_then_check, state_q == ST_ADDR, state_q == ST_CHECK, "map read not checked")
	`GRWC_ASSERT_IMP(a_out_from_done, $rose(out_valid_q), $past(state_q == ST_DONE), "result word without cast")

endmodule
